/* hdl/ncps_pkg.sv */
// Shared types and constants for the nearest color pixel search unit.
package ncps_pkg;

   // Command codes carried in req_tuser.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_WIDTH_IN_USE  = 1'b0;
   localparam logic CSR_HEIGHT_IN_USE = 1'b1;

   // Field widths fixed by the word formats.
   localparam int POS_BITS   = 8;
   localparam int COORD_BITS = 10;
   localparam int LIMIT_BITS = 9;
   localparam int DIST_BITS  = 18;
   localparam int SQ_BITS    = 16;

   // Best distance value that means no match has been recorded.
   localparam logic [DIST_BITS-1:0] BEST_NONE = '1;

   // A ring below this radius ends the search when it is done, once a match is recorded.
   localparam logic [POS_BITS-1:0] NEAR_RING_LIMIT = 8'd3;

   // Reset value of the image size registers.
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 9'd256;

   // One access to the image memory, by pixel coordinates.
   typedef struct packed {
      logic                  en;
      logic [LIMIT_BITS-1:0] x;
      logic [LIMIT_BITS-1:0] y;
   } ram_port_type;

endpackage

/* hdl/nearest_color_pixel_search_unit.sv */
// Top level of the nearest color pixel search unit: image store and ring search sequencer.
//
// The unit holds an image in an on-chip memory. A write word stores one pixel
// inside the built image and gives no response. A search word scans square rings
// of radius 0 up to search_range around the center, reading at most one pixel of
// the memory per cycle while it scans a ring edge, and returns one response with
// the nearest pixel of the wanted color and its squared distance. It stops early
// after a ring with no pixel inside the image, or after a ring below
// NEAR_RING_LIMIT once a match is recorded. The single memory read port and the
// one shared squaring unit set the pace of each ring. After the last ring the
// search squares the range, checks the best distance against it and loads the
// response. The unit is not ready for a new word while a search runs. The image
// memory has no reset; a search must only read pixels that have been written.
module nearest_color_pixel_search_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COLOR_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pos_x[7:0], pos_y[15:8], pixel_color[47:16],
                                    // search_range[55:48]
   input  logic        req_tuser,   // cmd
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // hit_x[7:0], hit_y[15:8], dist_sq[32:16], zero[39:33]
   output logic        rsp_tuser,   // found
   // Configuration writes.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);
   import ncps_pkg::*;

   typedef enum logic [3:0] {
      IDLE,
      RING_START,
      RING_SQ,
      SCAN,
      DRAIN,
      RING_END,
      RANGE_SQ,
      DONE
   } state_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // Control and search registers.
   state_type             state_ff,      state_in;
   logic [LIMIT_BITS-1:0] width_ff,      width_in;
   logic [LIMIT_BITS-1:0] height_ff,     height_in;
   logic [POS_BITS-1:0]   cx_ff,         cx_in;
   logic [POS_BITS-1:0]   cy_ff,         cy_in;
   logic [COLOR_BITS-1:0] color_ff,      color_in;
   logic [POS_BITS-1:0]   range_ff,      range_in;
   logic [POS_BITS-1:0]   radius_ff,     radius_in;
   logic signed [POS_BITS:0] ofs_ff,     ofs_in;
   logic                  side_ff,       side_in;
   logic                  vert_ff,       vert_in;
   logic                  ring_any_ff,   ring_any_in;
   logic [DIST_BITS-1:0]  best_ff,       best_in;
   logic [SQ_BITS-1:0]    best_pos_ff,   best_pos_in;
   logic [SQ_BITS-1:0]    rsq_ff,        rsq_in;
   logic [SQ_BITS-1:0]    mul_ff,        mul_in;
   logic                  p1_valid_ff,   p1_valid_in;
   logic [POS_BITS-1:0]   p1_x_ff,       p1_x_in;
   logic [POS_BITS-1:0]   p1_y_ff,       p1_y_in;
   logic                  rsp_valid_ff,  rsp_valid_in;
   logic                  rsp_found_ff,  rsp_found_in;
   logic [39:0]           rsp_data_ff,   rsp_data_in;

   // Request fields.
   logic [POS_BITS-1:0]   req_x;
   logic [POS_BITS-1:0]   req_y;
   logic [31:0]           req_color;
   logic [POS_BITS-1:0]   req_range;
   logic                  req_accept;

   // Scan point and shared squaring unit.
   coord_type             pt_x;
   coord_type             pt_y;
   logic                  pt_valid;
   logic [POS_BITS-1:0]   ofs_mag;
   logic [POS_BITS-1:0]   mul_a;
   coord_type             cx_s;
   coord_type             cy_s;
   coord_type             rad_s;
   coord_type             ofs_s;
   logic signed [POS_BITS:0] rad_ofs;
   logic                  ofs_at_end;

   // Compare stage and result.
   logic [DIST_BITS-1:0]  cand_dist;
   logic                  cand_hit;
   logic                  found;
   logic                  wr_x_ok;
   logic                  wr_y_ok;

   // Memory ports.
   ram_port_type          wr_port;
   ram_port_type          rd_port;
   logic [COLOR_BITS-1:0] rd_data;

   assign req_x      = req_tdata[7:0];
   assign req_y      = req_tdata[15:8];
   assign req_color  = req_tdata[47:16];
   assign req_range  = req_tdata[55:48];
   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Coordinates of the current ring point, as signed values.
   assign cx_s    = coord_type'({2'b00, cx_ff});
   assign cy_s    = coord_type'({2'b00, cy_ff});
   assign rad_s   = coord_type'({2'b00, radius_ff});
   assign ofs_s   = coord_type'({ofs_ff[POS_BITS], ofs_ff});
   assign rad_ofs = $signed({1'b0, radius_ff});

   always_comb begin
      if (!vert_ff) begin
         pt_x = cx_s + ofs_s;
         pt_y = side_ff ? (cy_s + rad_s) : (cy_s - rad_s);
      end else begin
         pt_x = side_ff ? (cx_s + rad_s) : (cx_s - rad_s);
         pt_y = cy_s + ofs_s;
      end
   end

   // A point counts when it lies inside both the configured and the built size.
   assign pt_valid = !pt_x[COORD_BITS-1] && !pt_y[COORD_BITS-1]
                  && (pt_x[LIMIT_BITS-1:0] < width_ff)
                  && (pt_y[LIMIT_BITS-1:0] < height_ff)
                  && ((MAX_WIDTH > 511)
                      || (pt_x[LIMIT_BITS-1:0] < LIMIT_BITS'(MAX_WIDTH)))
                  && ((MAX_HEIGHT > 511)
                      || (pt_y[LIMIT_BITS-1:0] < LIMIT_BITS'(MAX_HEIGHT)));

   // Horizontal edges run to +radius, vertical edges stop one short.
   assign ofs_at_end = vert_ff ? (ofs_ff == rad_ofs - 9'sd1) : (ofs_ff == rad_ofs);

   // Shared squaring unit: ring radius, range, or the offset along an edge.
   assign ofs_mag = ofs_ff[POS_BITS] ? POS_BITS'(-ofs_ff) : ofs_ff[POS_BITS-1:0];

   always_comb begin
      case (state_ff)
         RING_START:      mul_a = radius_ff;
         RANGE_SQ, DONE:  mul_a = range_ff;
         default:         mul_a = ofs_mag;
      endcase
   end

   assign mul_in = mul_a * mul_a;

   // Compare stage: the pixel read in the previous cycle against the best so far.
   assign cand_dist = {2'b00, mul_ff} + {2'b00, rsq_ff};
   assign cand_hit  = p1_valid_ff && (rd_data == color_ff) && (cand_dist < best_ff);

   // Range check on the final best distance; mul_ff holds the range squared.
   assign found = (best_ff != BEST_NONE) && (best_ff <= {2'b00, mul_ff});

   // Memory write for a pixel inside the built image.
   assign wr_x_ok = (MAX_WIDTH > 255) || (req_x < POS_BITS'(MAX_WIDTH));
   assign wr_y_ok = (MAX_HEIGHT > 255) || (req_y < POS_BITS'(MAX_HEIGHT));

   always_comb begin
      wr_port.en = req_accept && (req_tuser == CMD_WRITE) && wr_x_ok && wr_y_ok;
      wr_port.x  = {1'b0, req_x};
      wr_port.y  = {1'b0, req_y};
      rd_port.en = (state_ff == SCAN) && pt_valid;
      rd_port.x  = pt_x[LIMIT_BITS-1:0];
      rd_port.y  = pt_y[LIMIT_BITS-1:0];
   end

   ncps_image_ram #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COLOR_BITS (COLOR_BITS)
   ) u_image_ram (
      .clock   (clock),
      .wr_port (wr_port),
      .wr_data (req_color[COLOR_BITS-1:0]),
      .rd_port (rd_port),
      .rd_data (rd_data)
   );

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      color_in     = color_ff;
      range_in     = range_ff;
      radius_in    = radius_ff;
      ofs_in       = ofs_ff;
      side_in      = side_ff;
      vert_in      = vert_ff;
      ring_any_in  = ring_any_ff;
      best_in      = best_ff;
      best_pos_in  = best_pos_ff;
      rsq_in       = rsq_ff;
      p1_valid_in  = (state_ff == SCAN) && pt_valid;
      p1_x_in      = pt_x[POS_BITS-1:0];
      p1_y_in      = pt_y[POS_BITS-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_data_in  = rsp_data_ff;

      // The user must send configuration writes only while the unit is idle; the block does not enforce this.
      if (csr_we) begin
         case (csr_index)
            CSR_WIDTH_IN_USE:  width_in  = csr_wdata;
            CSR_HEIGHT_IN_USE: height_in = csr_wdata;
            default: ;
         endcase
      end

      // Record a closer match from the compare stage.
      if (cand_hit) begin
         best_in     = cand_dist;
         best_pos_in = {p1_y_ff, p1_x_ff};
      end

      case (state_ff)
         IDLE: begin
            if (req_accept && (req_tuser == CMD_SEARCH)) begin
               cx_in       = req_x;
               cy_in       = req_y;
               color_in    = req_color[COLOR_BITS-1:0];
               range_in    = req_range;
               radius_in   = '0;
               best_in     = BEST_NONE;
               best_pos_in = '0;
               state_in    = RING_START;
            end
         end
         RING_START: begin
            state_in = RING_SQ;
         end
         RING_SQ: begin
            rsq_in      = mul_ff;
            ofs_in      = -rad_ofs;
            side_in     = 1'b0;
            vert_in     = 1'b0;
            ring_any_in = 1'b0;
            state_in    = SCAN;
         end
         SCAN: begin
            ring_any_in = ring_any_ff || pt_valid;
            // Both sides at one offset, then the next offset, then the next edge pair.
            if (!side_ff && (radius_ff != '0)) begin
               side_in = 1'b1;
            end else begin
               side_in = 1'b0;
               if (ofs_at_end) begin
                  if (vert_ff || (radius_ff == '0)) begin
                     state_in = DRAIN;
                  end else begin
                     vert_in = 1'b1;
                     ofs_in  = 9'sd1 - rad_ofs;
                  end
               end else begin
                  ofs_in = ofs_ff + 9'sd1;
               end
            end
         end
         DRAIN: begin
            state_in = RING_END;
         end
         RING_END: begin
            // Stop on an empty ring, on an early near match, or at the last ring.
            if (!ring_any_ff
                || ((radius_ff < NEAR_RING_LIMIT) && (best_ff != BEST_NONE))
                || (radius_ff == range_ff)) begin
               state_in = RANGE_SQ;
            end else begin
               radius_in = radius_ff + 8'd1;
               state_in  = RING_START;
            end
         end
         RANGE_SQ: begin
            state_in = DONE;
         end
         DONE: begin
            // Load the response register once the previous word has gone.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found;
               rsp_data_in  = found
                  ? {7'd0, best_ff[16:0], best_pos_ff[15:8], best_pos_ff[7:0]}
                  : 40'd0;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         width_ff     <= LIMIT_RESET;
         height_ff    <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         best_ff      <= BEST_NONE;
         best_pos_ff  <= '0;
         radius_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff  <= p1_valid_in;
         best_ff      <= best_in;
         best_pos_ff  <= best_pos_in;
         radius_ff    <= radius_in;
      end
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      color_ff     <= color_in;
      range_ff     <= range_in;
      ofs_ff       <= ofs_in;
      side_ff      <= side_in;
      vert_ff      <= vert_in;
      ring_any_ff  <= ring_any_in;
      rsq_ff       <= rsq_in;
      mul_ff       <= mul_in;
      p1_x_ff      <= p1_x_in;
      p1_y_ff      <= p1_y_in;
      rsp_found_ff <= rsp_found_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* hdl/ncps_image_ram.sv */
// Image memory with one write port and one registered read port, addressed by pixel.
module ncps_image_ram #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int COLOR_BITS = 32
) (
   input  logic                   clock,
   input  ncps_pkg::ram_port_type wr_port,
   input  logic [COLOR_BITS-1:0]  wr_data,
   input  ncps_pkg::ram_port_type rd_port,
   output logic [COLOR_BITS-1:0]  rd_data
);
   import ncps_pkg::*;

   localparam int XB    = $clog2(MAX_WIDTH);
   localparam int YB    = $clog2(MAX_HEIGHT);
   localparam int DEPTH = 2 ** (XB + YB);

   logic [COLOR_BITS-1:0] mem [DEPTH];
   logic [COLOR_BITS-1:0] rd_data_ff;
   logic [XB+YB-1:0]      wr_addr;
   logic [XB+YB-1:0]      rd_addr;

   // Row in the upper address bits, column in the lower ones.
   assign wr_addr = {YB'(wr_port.y), XB'(wr_port.x)};
   assign rd_addr = {YB'(rd_port.y), XB'(rd_port.x)};

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_port.en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered and available in the cycle after the request.
   always_ff @(posedge clock) begin
      if (rd_port.en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
